// ===== src/rsv_pkg.sv =====
// rsv_pkg: item types, register indexes, verdict codes and helpers for the sequence validator
`timescale 1ns / 1ps
`default_nettype none

package rsv_pkg;

    // widths fixed by the packet header fields
    localparam int SRC_W   = 32;
    localparam int SEQ_W   = 16;
    localparam int CNT_W   = 32;
    localparam int PROBE_W = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // sequence number space, one bit wider than a sequence number
    localparam logic [SEQ_W:0] SEQ_MOD = 17'h10000;

    // counter saturation value
    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEQUENTIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROPOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISORDER   = 2'd2;

    // configuration reset values
    localparam logic [PROBE_W-1:0] MIN_SEQUENTIAL_RST = 8'd2;
    localparam logic [SEQ_W-1:0]   MAX_DROPOUT_RST    = 16'd3000;
    localparam logic [SEQ_W-1:0]   MAX_MISORDER_RST   = 16'd100;

    // per-packet verdict codes
    typedef enum logic [2:0] {
        VERDICT_IN_ORDER    = 3'd0,
        VERDICT_PROBING     = 3'd1,
        VERDICT_PROBE_DONE  = 3'd2,
        VERDICT_JUMP_OK     = 3'd3,
        VERDICT_RESYNC      = 3'd4,
        VERDICT_BAD_PENDING = 3'd5,
        VERDICT_LATE        = 3'd6
    } verdict_t;

    // one received packet header
    typedef struct packed {
        logic [SRC_W-1:0] source_id;
        logic [SEQ_W-1:0] seq_num;
    } in_item_t;

    // one per-packet result
    typedef struct packed {
        logic             accepted;
        logic             sync_complete;
        logic             new_source;
        verdict_t         verdict;
        logic [CNT_W-1:0] received_total;
        logic [CNT_W-1:0] dropped_total;
        logic [CNT_W-1:0] seq_fail_total;
        logic [CNT_W-1:0] resync_total;
        logic [CNT_W-1:0] sources_seen;
        logic [CNT_W-1:0] sources_synced;
    } out_item_t;

    // saturating increment under an enable
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
        logic [CNT_W-1:0] r;
        r = v;
        if (en && (v != CNT_MAX))
        begin
            r = v + 32'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/rtp_sequence_validator.sv =====
// rtp_sequence_validator: top level, sequence number check and all-time counters
`timescale 1ns / 1ps
`default_nettype none

// Checks the sequence number of each received packet against the tracked source
// and keeps saturating all-time counters. One item is taken every cycle while
// the result register can advance. Results pass the input register, then the
// result register; the compare-and-update of the source state between them is
// combinational, so consecutive packets of the same source need no spacing.
// The user must write configuration only while the block is idle (unenforced).
module rtp_sequence_validator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire rsv_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output rsv_pkg::out_item_t                  out_data,
    input  wire logic                           cfg_we,
    input  wire logic [rsv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rsv_pkg::CFG_W-1:0]      cfg_data
);

    // configuration registers
    logic [rsv_pkg::PROBE_W-1:0] min_seq_reg;
    logic [rsv_pkg::SEQ_W-1:0]   max_dropout_reg;
    logic [rsv_pkg::SEQ_W-1:0]   max_misorder_reg;

    // pipeline registers
    logic                  s1_valid_reg;
    rsv_pkg::in_item_t     s1_data_reg;
    logic                  out_valid_reg;
    rsv_pkg::out_item_t    out_data_reg;
    rsv_pkg::out_item_t    out_data_next;

    // source tracking state
    logic                        source_valid_reg;
    logic [rsv_pkg::SRC_W-1:0]   current_source_reg;
    logic [rsv_pkg::SEQ_W-1:0]   last_seq_reg;
    logic [rsv_pkg::SEQ_W-1:0]   last_seq_next;
    logic [rsv_pkg::PROBE_W-1:0] probe_count_reg;
    logic [rsv_pkg::PROBE_W-1:0] probe_count_next;
    logic                        bad_pending_reg;
    logic                        bad_pending_next;
    logic [rsv_pkg::SEQ_W-1:0]   bad_seq_reg;
    logic [rsv_pkg::SEQ_W-1:0]   bad_seq_next;

    // all-time counters
    logic [rsv_pkg::CNT_W-1:0] count_received_reg;
    logic [rsv_pkg::CNT_W-1:0] count_received_next;
    logic [rsv_pkg::CNT_W-1:0] count_dropped_reg;
    logic [rsv_pkg::CNT_W-1:0] count_dropped_next;
    logic [rsv_pkg::CNT_W-1:0] count_seq_fail_reg;
    logic [rsv_pkg::CNT_W-1:0] count_seq_fail_next;
    logic [rsv_pkg::CNT_W-1:0] count_resync_reg;
    logic [rsv_pkg::CNT_W-1:0] count_resync_next;
    logic [rsv_pkg::CNT_W-1:0] count_sources_reg;
    logic [rsv_pkg::CNT_W-1:0] count_sources_next;
    logic [rsv_pkg::CNT_W-1:0] count_synced_reg;
    logic [rsv_pkg::CNT_W-1:0] count_synced_next;

    // per-item decision signals
    logic                        advance;
    logic                        s1_fire;
    logic                        is_new;
    logic [rsv_pkg::SEQ_W-1:0]   seq;
    logic [rsv_pkg::SEQ_W-1:0]   base_last;
    logic [rsv_pkg::PROBE_W-1:0] base_probe;
    logic                        base_bad_pending;
    logic [rsv_pkg::SEQ_W-1:0]   base_bad_seq;
    logic [rsv_pkg::SEQ_W-1:0]   delta;
    logic                        in_seq;
    logic                        acc;
    logic                        sync;
    logic                        seq_fail;
    logic                        resync;
    rsv_pkg::verdict_t           verdict;

    // flow control: result register frees when empty or taken
    assign advance  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_seq_reg      <= rsv_pkg::MIN_SEQUENTIAL_RST;
            max_dropout_reg  <= rsv_pkg::MAX_DROPOUT_RST;
            max_misorder_reg <= rsv_pkg::MAX_MISORDER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsv_pkg::CFG_MIN_SEQUENTIAL: min_seq_reg <= cfg_data[rsv_pkg::PROBE_W-1:0];
                rsv_pkg::CFG_MAX_DROPOUT:    max_dropout_reg <= cfg_data;
                rsv_pkg::CFG_MAX_MISORDER:   max_misorder_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
    end

    // source restart view of the state
    always_comb
    begin
        seq              = s1_data_reg.seq_num;
        is_new           = !source_valid_reg || (s1_data_reg.source_id != current_source_reg);
        base_last        = is_new ? '0 : last_seq_reg;
        base_probe       = is_new ? '0 : probe_count_reg;
        base_bad_pending = is_new ? 1'b0 : bad_pending_reg;
        base_bad_seq     = is_new ? '0 : bad_seq_reg;
        in_seq           = (seq == base_last + 16'd1);
        delta            = seq - base_last;
    end

    // probation and sequence decision
    always_comb
    begin
        last_seq_next    = base_last;
        probe_count_next = base_probe;
        bad_pending_next = base_bad_pending;
        bad_seq_next     = base_bad_seq;
        acc              = 1'b0;
        sync             = 1'b0;
        seq_fail         = 1'b0;
        resync           = 1'b0;
        verdict          = rsv_pkg::VERDICT_PROBING;
        if (base_probe < min_seq_reg)
        begin
            // probation
            last_seq_next = seq;
            if ((base_probe != '0) && in_seq)
            begin
                probe_count_next = base_probe + 8'd1;
                if (probe_count_next == min_seq_reg)
                begin
                    acc     = 1'b1;
                    sync    = 1'b1;
                    verdict = rsv_pkg::VERDICT_PROBE_DONE;
                end
            end
            else
            begin
                probe_count_next = 8'd1;
            end
        end
        else if (in_seq)
        begin
            last_seq_next = seq;
            acc           = 1'b1;
            verdict       = rsv_pkg::VERDICT_IN_ORDER;
        end
        else
        begin
            seq_fail = 1'b1;
            if (delta < max_dropout_reg)
            begin
                last_seq_next = seq;
                acc           = 1'b1;
                verdict       = rsv_pkg::VERDICT_JUMP_OK;
            end
            else if ({1'b0, delta} <= (rsv_pkg::SEQ_MOD - {1'b0, max_misorder_reg}))
            begin
                // big jump: resync when it follows the remembered one
                if (base_bad_pending && (seq == base_bad_seq + 16'd1))
                begin
                    resync           = 1'b1;
                    bad_pending_next = 1'b0;
                    bad_seq_next     = '0;
                    last_seq_next    = seq;
                    acc              = 1'b1;
                    verdict          = rsv_pkg::VERDICT_RESYNC;
                end
                else
                begin
                    bad_pending_next = 1'b1;
                    bad_seq_next     = seq;
                    verdict          = rsv_pkg::VERDICT_BAD_PENDING;
                end
            end
            else
            begin
                verdict = rsv_pkg::VERDICT_LATE;
            end
        end
    end

    // counter updates and result assembly
    always_comb
    begin
        count_sources_next  = rsv_pkg::sat_inc(count_sources_reg, is_new);
        count_received_next = rsv_pkg::sat_inc(count_received_reg, 1'b1);
        count_dropped_next  = rsv_pkg::sat_inc(count_dropped_reg, !acc);
        count_seq_fail_next = rsv_pkg::sat_inc(count_seq_fail_reg, seq_fail);
        count_resync_next   = rsv_pkg::sat_inc(count_resync_reg, resync);
        count_synced_next   = rsv_pkg::sat_inc(count_synced_reg, sync);

        out_data_next.accepted       = acc;
        out_data_next.sync_complete  = sync;
        out_data_next.new_source     = is_new;
        out_data_next.verdict        = verdict;
        out_data_next.received_total = count_received_next;
        out_data_next.dropped_total  = count_dropped_next;
        out_data_next.seq_fail_total = count_seq_fail_next;
        out_data_next.resync_total   = count_resync_next;
        out_data_next.sources_seen   = count_sources_next;
        out_data_next.sources_synced = count_synced_next;
    end

    // source state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_valid_reg   <= 1'b0;
            current_source_reg <= '0;
            last_seq_reg       <= '0;
            probe_count_reg    <= '0;
            bad_pending_reg    <= 1'b0;
            bad_seq_reg        <= '0;
            count_received_reg <= '0;
            count_dropped_reg  <= '0;
            count_seq_fail_reg <= '0;
            count_resync_reg   <= '0;
            count_sources_reg  <= '0;
            count_synced_reg   <= '0;
        end
        else if (s1_fire)
        begin
            source_valid_reg   <= 1'b1;
            current_source_reg <= s1_data_reg.source_id;
            last_seq_reg       <= last_seq_next;
            probe_count_reg    <= probe_count_next;
            bad_pending_reg    <= bad_pending_next;
            bad_seq_reg        <= bad_seq_next;
            count_received_reg <= count_received_next;
            count_dropped_reg  <= count_dropped_next;
            count_seq_fail_reg <= count_seq_fail_next;
            count_resync_reg   <= count_resync_next;
            count_sources_reg  <= count_sources_next;
            count_synced_reg   <= count_synced_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // an empty input register never pushes back
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    // a processed item always leaves a tracked source
    a_source_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> source_valid_reg)
        else $error("source not tracked after an item");

    // end of probation is always an accepted probe-done result
    a_sync_is_probe_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.sync_complete) |->
            (out_data.accepted && (out_data.verdict == rsv_pkg::VERDICT_PROBE_DONE)))
        else $error("sync_complete without probe-done acceptance");

    // drops never outnumber receptions
    a_drop_le_received: assert property (@(posedge clk) disable iff (!rst_n)
        count_dropped_reg <= count_received_reg)
        else $error("dropped count exceeds received count");
`endif

endmodule

`default_nettype wire

// ===== tb/rtp_sequence_validator_tb.sv =====
// rtp_sequence_validator_tb: self-checking bench, directed packet script then random source streams
`timescale 1ns / 1ps

module rtp_sequence_validator_tb;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 240;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int HOLD_OFF_AT     = 400;
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_REPORTS     = 10;

    // index past the last register, writes to it must be ignored
    localparam logic [rsv_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // one line of the opening script: a register write or a packet
    typedef struct packed {
        bit                            is_write;
        logic [rsv_pkg::CFG_IDX_W-1:0] reg_index;
        logic [rsv_pkg::CFG_W-1:0]     reg_value;
        logic [rsv_pkg::SRC_W-1:0]     source_id;
        logic [rsv_pkg::SEQ_W-1:0]     seq_num;
        bit                            known;
        logic                          accepted;
        logic                          sync_complete;
        logic                          new_source;
        rsv_pkg::verdict_t             verdict;
    } script_row_t;

    // block inputs, known from time zero
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    rsv_pkg::in_item_t  in_data   = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [rsv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rsv_pkg::CFG_W-1:0]     cfg_data  = '0;

    logic               in_stall;
    logic               out_valid;
    rsv_pkg::out_item_t out_data;

    // predictor copy of the limits
    logic [rsv_pkg::PROBE_W-1:0] lim_min_seq  = rsv_pkg::MIN_SEQUENTIAL_RST;
    logic [rsv_pkg::SEQ_W-1:0]   lim_dropout  = rsv_pkg::MAX_DROPOUT_RST;
    logic [rsv_pkg::SEQ_W-1:0]   lim_misorder = rsv_pkg::MAX_MISORDER_RST;

    // predictor copy of the tracked source
    bit                          trk_valid       = 1'b0;
    logic [rsv_pkg::SRC_W-1:0]   trk_source      = '0;
    logic [rsv_pkg::SEQ_W-1:0]   trk_last        = '0;
    logic [rsv_pkg::PROBE_W-1:0] trk_probes      = '0;
    bit                          trk_bad_pending = 1'b0;
    logic [rsv_pkg::SEQ_W-1:0]   trk_bad_seq     = '0;

    // predictor copy of the all-time counters
    logic [rsv_pkg::CNT_W-1:0] tally_received = '0;
    logic [rsv_pkg::CNT_W-1:0] tally_dropped  = '0;
    logic [rsv_pkg::CNT_W-1:0] tally_seq_fail = '0;
    logic [rsv_pkg::CNT_W-1:0] tally_resync   = '0;
    logic [rsv_pkg::CNT_W-1:0] tally_sources  = '0;
    logic [rsv_pkg::CNT_W-1:0] tally_synced   = '0;

    rsv_pkg::out_item_t        pending_results[$];
    rsv_pkg::out_item_t        want_now;
    script_row_t               opening_script[$];
    logic [rsv_pkg::SRC_W-1:0] source_pool[4];
    bit no_gaps         = 1'b0;
    int mismatches      = 0;
    int results_checked = 0;
    int cycle_count     = 0;

    rtp_sequence_validator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // saturating count step
    function automatic logic [rsv_pkg::CNT_W-1:0] bump(input logic [rsv_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // sequence check of one packet, updates the tracked state and counters
    function automatic rsv_pkg::out_item_t validate_packet(
        input logic [rsv_pkg::SRC_W-1:0] src,
        input logic [rsv_pkg::SEQ_W-1:0] seq);
        rsv_pkg::out_item_t        res;
        logic [rsv_pkg::SEQ_W-1:0] next_up;
        logic [rsv_pkg::SEQ_W-1:0] bad_next;
        logic [rsv_pkg::SEQ_W-1:0] ahead;
        logic [rsv_pkg::SEQ_W:0]   late_edge;
        res = '0;
        res.verdict = rsv_pkg::VERDICT_PROBING;
        // new or changed source restarts probation
        if (!trk_valid || src != trk_source)
        begin
            res.new_source  = 1'b1;
            trk_valid       = 1'b1;
            trk_source      = src;
            trk_last        = '0;
            trk_probes      = '0;
            trk_bad_pending = 1'b0;
            trk_bad_seq     = '0;
            tally_sources   = bump(tally_sources);
        end
        tally_received = bump(tally_received);
        next_up  = trk_last + 16'd1;
        bad_next = trk_bad_seq + 16'd1;
        if (trk_probes < lim_min_seq)
        begin
            // probation
            if (trk_probes == '0)
            begin
                trk_last   = seq;
                trk_probes = 8'd1;
            end
            else if (seq == next_up)
            begin
                trk_last   = seq;
                trk_probes = trk_probes + 8'd1;
                if (trk_probes == lim_min_seq)
                begin
                    res.accepted      = 1'b1;
                    res.sync_complete = 1'b1;
                    res.verdict       = rsv_pkg::VERDICT_PROBE_DONE;
                    tally_synced      = bump(tally_synced);
                end
            end
            else
            begin
                trk_probes = 8'd1;
                trk_last   = seq;
            end
        end
        else if (seq == next_up)
        begin
            trk_last     = seq;
            res.accepted = 1'b1;
            res.verdict  = rsv_pkg::VERDICT_IN_ORDER;
        end
        else
        begin
            // out of sequence after sync
            ahead          = seq - trk_last;
            late_edge      = rsv_pkg::SEQ_MOD - {1'b0, lim_misorder};
            tally_seq_fail = bump(tally_seq_fail);
            if (ahead < lim_dropout)
            begin
                trk_last     = seq;
                res.accepted = 1'b1;
                res.verdict  = rsv_pkg::VERDICT_JUMP_OK;
            end
            else if ({1'b0, ahead} <= late_edge)
            begin
                if (trk_bad_pending && seq == bad_next)
                begin
                    tally_resync    = bump(tally_resync);
                    trk_bad_pending = 1'b0;
                    trk_bad_seq     = '0;
                    trk_last        = seq;
                    res.accepted    = 1'b1;
                    res.verdict     = rsv_pkg::VERDICT_RESYNC;
                end
                else
                begin
                    trk_bad_pending = 1'b1;
                    trk_bad_seq     = seq;
                    res.verdict     = rsv_pkg::VERDICT_BAD_PENDING;
                end
            end
            else
            begin
                res.verdict = rsv_pkg::VERDICT_LATE;
            end
        end
        if (!res.accepted)
        begin
            tally_dropped = bump(tally_dropped);
        end
        res.received_total = tally_received;
        res.dropped_total  = tally_dropped;
        res.seq_fail_total = tally_seq_fail;
        res.resync_total   = tally_resync;
        res.sources_seen   = tally_sources;
        res.sources_synced = tally_synced;
        return res;
    endfunction

    // script rows
    function automatic script_row_t packet_row(input logic [rsv_pkg::SRC_W-1:0] src,
                                               input logic [rsv_pkg::SEQ_W-1:0] seq);
        script_row_t r;
        r = '0;
        r.source_id = src;
        r.seq_num   = seq;
        return r;
    endfunction

    function automatic script_row_t known_row(input logic [rsv_pkg::SRC_W-1:0] src,
                                              input logic [rsv_pkg::SEQ_W-1:0] seq,
                                              input logic acc, input logic sync,
                                              input logic fresh, input rsv_pkg::verdict_t v);
        script_row_t r;
        r = packet_row(src, seq);
        r.known         = 1'b1;
        r.accepted      = acc;
        r.sync_complete = sync;
        r.new_source    = fresh;
        r.verdict       = v;
        return r;
    endfunction

    function automatic script_row_t reg_row(input logic [rsv_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [rsv_pkg::CFG_W-1:0] val);
        script_row_t r;
        r = '0;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    // sender idle length, mostly short
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [rsv_pkg::SRC_W-1:0] pick_source();
        int r;
        r = $urandom_range(0, 19);
        if (r < 17)
        begin
            return source_pool[r[1:0]];
        end
        return $urandom;
    endfunction

    // offer one item, predict it once accepted
    task automatic send_packet(input script_row_t row);
        int                 gap;
        rsv_pkg::out_item_t predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.source_id <= row.source_id;
        in_data.seq_num   <= row.seq_num;
        in_valid          <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = validate_packet(row.source_id, row.seq_num);
        if (row.known)
        begin
            predicted.accepted      = row.accepted;
            predicted.sync_complete = row.sync_complete;
            predicted.new_source    = row.new_source;
            predicted.verdict       = row.verdict;
        end
        pending_results.push_back(predicted);
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [rsv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rsv_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rsv_pkg::CFG_MIN_SEQUENTIAL: lim_min_seq  = val[rsv_pkg::PROBE_W-1:0];
            rsv_pkg::CFG_MAX_DROPOUT:    lim_dropout  = val;
            rsv_pkg::CFG_MAX_MISORDER:   lim_misorder = val;
            default: ;
        endcase
    endtask

    task automatic report_field(input string field, input logic [rsv_pkg::CNT_W-1:0] want,
                                input logic [rsv_pkg::CNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t result %0d: %s expected %0h got %0h",
                         $realtime, results_checked, field, want, got);
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t unexpected result, verdict %0d", $realtime, out_data.verdict);
                end
            end
            else
            begin
                want_now = pending_results.pop_front();
                report_field("accepted", 32'(want_now.accepted), 32'(out_data.accepted));
                report_field("sync_complete", 32'(want_now.sync_complete),
                             32'(out_data.sync_complete));
                report_field("new_source", 32'(want_now.new_source), 32'(out_data.new_source));
                report_field("verdict", 32'(want_now.verdict), 32'(out_data.verdict));
                report_field("received_total", want_now.received_total, out_data.received_total);
                report_field("dropped_total", want_now.dropped_total, out_data.dropped_total);
                report_field("seq_fail_total", want_now.seq_fail_total, out_data.seq_fail_total);
                report_field("resync_total", want_now.resync_total, out_data.resync_total);
                report_field("sources_seen", want_now.sources_seen, out_data.sources_seen);
                report_field("sources_synced", want_now.sources_synced, out_data.sources_synced);
            end
            results_checked++;
        end
    end

    // receiver stalls, plus one long hold-off that backs up the block
    initial
    begin : receiver_pacing
        int span;
        int roll;
        bit held_once;
        span = 0;
        held_once = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_once && results_checked >= HOLD_OFF_AT)
            begin
                held_once = 1'b1;
                out_stall <= 1'b1;
                span = HOLD_OFF_CYCLES - 1;
            end
            else if (span > 0)
            begin
                span--;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    out_stall <= 1'b0;
                    span = $urandom_range(0, 40);
                end
                else if (roll < 85)
                begin
                    out_stall <= 1'b1;
                    span = $urandom_range(0, 2);
                end
                else if (roll < 97)
                begin
                    out_stall <= 1'b1;
                    span = $urandom_range(3, 14);
                end
                else
                begin
                    out_stall <= 1'b1;
                    span = $urandom_range(20, 60);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int                        phase;
        int                        k;
        int                        len;
        int                        sent;
        int                        roll;
        logic [rsv_pkg::SRC_W-1:0] src;
        logic [rsv_pkg::SEQ_W-1:0] head;
        logic [rsv_pkg::SEQ_W-1:0] seq;
        logic [rsv_pkg::CFG_W-1:0] new_min;
        logic [rsv_pkg::CFG_W-1:0] new_drop;
        logic [rsv_pkg::CFG_W-1:0] new_mis;
        bit                        flaky;
        bit                        follow;

        // first source, in order, duplicate, late, big jump and resync, wrap
        opening_script.push_back(known_row(32'h0, 16'd0, 1'b0, 1'b0, 1'b1,
                                           rsv_pkg::VERDICT_PROBING));
        opening_script.push_back(known_row(32'h0, 16'd1, 1'b1, 1'b1, 1'b0,
                                           rsv_pkg::VERDICT_PROBE_DONE));
        opening_script.push_back(known_row(32'h0, 16'd2, 1'b1, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_IN_ORDER));
        opening_script.push_back(known_row(32'h0, 16'd2, 1'b1, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_JUMP_OK));
        opening_script.push_back(packet_row(32'h0, 16'd100));
        opening_script.push_back(known_row(32'h0, 16'd50, 1'b0, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_LATE));
        opening_script.push_back(known_row(32'h0, 16'd20000, 1'b0, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_BAD_PENDING));
        opening_script.push_back(known_row(32'h0, 16'd20001, 1'b1, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_RESYNC));
        opening_script.push_back(packet_row(32'h0, 16'hFFFF));
        opening_script.push_back(packet_row(32'h0, 16'h0000));
        // source change, broken probe
        opening_script.push_back(known_row(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1,
                                           rsv_pkg::VERDICT_PROBING));
        opening_script.push_back(known_row(32'hFFFF_FFFF, 16'd5, 1'b0, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_PROBING));
        opening_script.push_back(known_row(32'hFFFF_FFFF, 16'd6, 1'b1, 1'b1, 1'b0,
                                           rsv_pkg::VERDICT_PROBE_DONE));
        // probation of one packet syncs without a probe-done item
        opening_script.push_back(reg_row(rsv_pkg::CFG_MIN_SEQUENTIAL, 16'd1));
        opening_script.push_back(known_row(32'h1234_5678, 16'h8000, 1'b0, 1'b0, 1'b1,
                                           rsv_pkg::VERDICT_PROBING));
        opening_script.push_back(known_row(32'h1234_5678, 16'h8001, 1'b1, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_IN_ORDER));
        // no probation, synced at once from zero
        opening_script.push_back(reg_row(rsv_pkg::CFG_MIN_SEQUENTIAL, 16'd0));
        opening_script.push_back(known_row(32'hA5A5_A5A5, 16'd1, 1'b1, 1'b0, 1'b1,
                                           rsv_pkg::VERDICT_IN_ORDER));
        // zero limits: duplicate is a big jump, never late
        opening_script.push_back(reg_row(rsv_pkg::CFG_MAX_DROPOUT, 16'd0));
        opening_script.push_back(reg_row(rsv_pkg::CFG_MAX_MISORDER, 16'd0));
        opening_script.push_back(known_row(32'hA5A5_A5A5, 16'd1, 1'b0, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_BAD_PENDING));
        opening_script.push_back(packet_row(32'hA5A5_A5A5, 16'h8000));
        opening_script.push_back(known_row(32'hA5A5_A5A5, 16'h8001, 1'b1, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_RESYNC));
        // full limits, spare index ignored
        opening_script.push_back(reg_row(rsv_pkg::CFG_MAX_DROPOUT, 16'hFFFF));
        opening_script.push_back(reg_row(rsv_pkg::CFG_MAX_MISORDER, 16'hFFFF));
        opening_script.push_back(reg_row(CFG_SPARE, 16'hFFFF));
        opening_script.push_back(known_row(32'hA5A5_A5A5, 16'h8000, 1'b0, 1'b0, 1'b0,
                                           rsv_pkg::VERDICT_LATE));
        opening_script.push_back(packet_row(32'hA5A5_A5A5, 16'h7FFF));
        opening_script.push_back(reg_row(rsv_pkg::CFG_MIN_SEQUENTIAL, 16'd255));
        opening_script.push_back(known_row(32'h5A5A_5A5A, 16'd0, 1'b0, 1'b0, 1'b1,
                                           rsv_pkg::VERDICT_PROBING));

        // reset
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (opening_script[i])
        begin
            if (opening_script[i].is_write)
            begin
                settle();
                write_reg(opening_script[i].reg_index, opening_script[i].reg_value);
            end
            else
            begin
                send_packet(opening_script[i]);
            end
        end

        // random streams, one limit setting per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    new_min  = 16'd2;
                    new_drop = 16'd3000;
                    new_mis  = 16'd100;
                end
                1:
                begin
                    new_min  = 16'd0;
                    new_drop = 16'd0;
                    new_mis  = 16'd0;
                end
                2:
                begin
                    new_min  = 16'h00FF;
                    new_drop = 16'hFFFF;
                    new_mis  = 16'hFFFF;
                end
                3:
                begin
                    new_min  = 16'd1;
                    new_drop = 16'd1;
                    new_mis  = 16'd1;
                end
                default:
                begin
                    new_min  = {8'($urandom), 8'($urandom_range(0, 6))};
                    new_drop = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(1, 4000));
                    new_mis  = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 300));
                end
            endcase
            settle();
            write_reg(rsv_pkg::CFG_MIN_SEQUENTIAL, new_min);
            write_reg(rsv_pkg::CFG_MAX_DROPOUT, new_drop);
            write_reg(rsv_pkg::CFG_MAX_MISORDER, new_mis);
            source_pool[0] = $urandom;
            source_pool[1] = $urandom;
            source_pool[2] = (phase % 2 == 0) ? 32'h0 : $urandom;
            source_pool[3] = (phase % 2 == 1) ? 32'hFFFF_FFFF : $urandom;
            no_gaps = (phase % 3 == 1);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // one stream: probation, then mostly in order with faults mixed in
                src   = pick_source();
                head  = 16'($urandom);
                flaky = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                begin
                    len = $urandom_range(1, 6);
                end
                else
                begin
                    len = int'(lim_min_seq) + $urandom_range(2, 40);
                end
                for (k = 0; k < len; k++)
                begin
                    follow = 1'b0;
                    roll = $urandom_range(0, 99);
                    if (k == 0)
                    begin
                        seq = head;
                    end
                    else if (k <= int'(lim_min_seq))
                    begin
                        head = (flaky && roll < 5) ? 16'($urandom) : head + 16'd1;
                        seq = head;
                    end
                    else if (roll < 70)
                    begin
                        head = head + 16'd1;
                        seq = head;
                    end
                    else if (roll < 76)
                    begin
                        seq = head;
                    end
                    else if (roll < 82)
                    begin
                        head = head + 16'($urandom_range(2, int'(lim_dropout) + 1));
                        seq = head;
                    end
                    else if (roll < 88)
                    begin
                        seq = head - 16'($urandom_range(1, int'(lim_misorder) + 1));
                    end
                    else if (roll < 94)
                    begin
                        head = head + 16'($urandom_range(int'(lim_dropout),
                                                         65536 - int'(lim_misorder)));
                        seq = head;
                        follow = 1'b1;
                    end
                    else if (roll < 97)
                    begin
                        head = 16'($urandom);
                        seq = head;
                    end
                    else
                    begin
                        // stray packet from some other source
                        seq = head;
                        send_packet(packet_row($urandom, 16'($urandom)));
                        sent++;
                    end
                    send_packet(packet_row(src, seq));
                    sent++;
                    if (follow)
                    begin
                        head = head + 16'd1;
                        send_packet(packet_row(src, head));
                        sent++;
                    end
                end
            end
        end

        // drain and report
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rsv_pkg.sv
src/rtp_sequence_validator.sv
tb/rtp_sequence_validator_tb.sv
